// File: rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table core: table geometry,
// operation codes and the command and status bundles between control and
// datapath.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W         = 5;
  localparam int OP_W          = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    POS_NONE = 2'd0,
    POS_SLOT = 2'd1,
    POS_MID  = 2'd2
  } pos_sel_e;

  typedef struct packed {
    logic     load;       // capture operation and value
    logic     clear;      // empty the table
    logic     ins_init;   // start insert walk from the top entry
    logic     shift;      // move read entry up one place
    logic     place;      // write new value into the gap
    logic     srch_init;  // open search range over the held entries
    logic     probe;      // latch midpoint and read it
    logic     narrow;     // narrow the range to exclude the midpoint
    logic     finish;     // register the result
    pos_sel_e pos_sel;
    logic     found;
    logic     full;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic slot_zero;
    logic rd_gt;
    logic rd_eq;
    logic range_empty;
  } dp_status_t;

endpackage

// File: rtl/sorted_table_insert_and_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_and_binary_search_core
// Sorted table of signed entries with clear, ordered insert and binary search.
//
// Command channel: a command transfers at a rising edge with start high and
// busy low; operation_i and value_i are sampled then. busy stays high until
// the command has finished, and a new command may transfer in the very cycle
// its predecessor's result is shown.
// Result channel: done_o is high for exactly one cycle per command, with
// position_o, found_o, table_full_o and entry_count_o valid in that cycle.
// There is no back-pressure; the receiver must take each result as shown.
// Sequence after the transfer edge:
//   clear, refused insert, unused code: decoded, then the result is registered
//   insert: decoded, then a shift walk through the table memory moves each
//     entry greater than the value up one place, one entry per cycle, and the
//     value is then written into the gap
//   search: decoded, then probes of one memory read and one compare each, until a hit or an empty range
// Commands are served one at a time: a new command is not accepted until the
// last one's result is shown. Reset empties the table; entries are not cleared in storage.
// ----------------------------------------------------------------------------
module sorted_table_insert_and_binary_search_core import stbs_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [OP_W-1:0]                 operation_i,
  input  logic signed [ELEMENT_WIDTH-1:0] value_i,
  output logic                            done_o,
  output logic signed [POS_W-1:0]         position_o,
  output logic                            found_o,
  output logic                            table_full_o,
  output logic [CNT_W-1:0]                entry_count_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  stbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  stbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .status_o      (status),
    .done_o        (done_o),
    .position_o    (position_o),
    .found_o       (found_o),
    .table_full_o  (table_full_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// File: rtl/stbs_dp.sv
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: table memory, entry count, insert slot pointer, search bounds,
// comparator and the result registers.
// ----------------------------------------------------------------------------
module stbs_dp import stbs_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dp_cmd_t                         cmd_i,
  input  logic [OP_W-1:0]                 operation_i,
  input  logic signed [ELEMENT_WIDTH-1:0] value_i,
  output dp_status_t                      status_o,
  output logic                            done_o,
  output logic signed [POS_W-1:0]         position_o,
  output logic                            found_o,
  output logic                            table_full_o,
  output logic [CNT_W-1:0]                entry_count_o
);

  logic signed [ELEMENT_WIDTH-1:0] mem [TABLE_DEPTH];

  op_e                             op_q;
  logic signed [ELEMENT_WIDTH-1:0] val_q;
  logic signed [ELEMENT_WIDTH-1:0] rdata_q;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [IDX_W-1:0]                slot_q;
  logic [CNT_W-1:0]                low_q, hi_q;
  logic [IDX_W-1:0]                mid_q;
  logic [CNT_W:0]                  mid_sum;
  logic [IDX_W-1:0]                mid_w;
  logic [IDX_W-1:0]                rd_addr;
  logic                            we;
  logic signed [ELEMENT_WIDTH-1:0] wdata;
  logic                            done_q;
  logic signed [POS_W-1:0]         pos_q, pos_d;
  logic                            found_q, full_q;
  logic [CNT_W-1:0]                ecount_q;

  // midpoint of the half-open range [low, hi)
  assign mid_sum = (CNT_W+1)'(low_q) + (CNT_W+1)'(hi_q) - (CNT_W+1)'(1);
  assign mid_w   = mid_sum[IDX_W:1];

  always_comb begin
    if (cmd_i.ins_init) begin
      rd_addr = IDX_W'(count_q - CNT_W'(1));
    end else if (cmd_i.shift) begin
      rd_addr = slot_q - IDX_W'(2);
    end else begin
      rd_addr = mid_w;
    end
  end

  assign we    = cmd_i.shift | cmd_i.place;
  assign wdata = cmd_i.shift ? rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[slot_q] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.place) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.pos_sel)
      POS_SLOT: pos_d = POS_W'(slot_q);
      POS_MID:  pos_d = POS_W'(mid_q);
      default:  pos_d = '1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      val_q <= value_i;
    end
    if (cmd_i.ins_init) begin
      slot_q <= IDX_W'(count_q);
    end else if (cmd_i.shift) begin
      slot_q <= slot_q - IDX_W'(1);
    end
    if (cmd_i.srch_init) begin
      low_q <= '0;
      hi_q  <= count_q;
    end else if (cmd_i.narrow) begin
      if (rdata_q > val_q) begin
        hi_q <= CNT_W'(mid_q);
      end else begin
        low_q <= CNT_W'(mid_q) + CNT_W'(1);
      end
    end
    if (cmd_i.probe) begin
      mid_q <= mid_w;
    end
    if (cmd_i.finish) begin
      pos_q    <= pos_d;
      found_q  <= cmd_i.found;
      full_q   <= cmd_i.full;
      ecount_q <= count_d;
    end
  end

  assign status_o.op          = op_q;
  assign status_o.full        = (count_q == CNT_W'(TABLE_DEPTH));
  assign status_o.slot_zero   = (slot_q == '0);
  assign status_o.rd_gt       = (rdata_q > val_q);
  assign status_o.rd_eq       = (rdata_q == val_q);
  assign status_o.range_empty = (hi_q <= low_q);

  assign done_o        = done_q;
  assign position_o    = pos_q;
  assign found_o       = found_q;
  assign table_full_o  = full_q;
  assign entry_count_o = ecount_q;

endmodule

// File: rtl/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: sequences the insert walk and the binary search probes and
// issues one result per accepted command.
// ----------------------------------------------------------------------------
module stbs_ctrl import stbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_DECODE     = 5'b00010,
    S_INS_SHIFT  = 5'b00100,
    S_SRCH_ISSUE = 5'b01000,
    S_SRCH_CMP   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.pos_sel = POS_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op)
          OP_CLEAR: begin
            cmd_o.clear  = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
          OP_INSERT: begin
            if (status_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.full   = 1'b1;
              state_d      = S_IDLE;
            end else begin
              cmd_o.ins_init = 1'b1;
              state_d        = S_INS_SHIFT;
            end
          end
          OP_SEARCH: begin
            cmd_o.srch_init = 1'b1;
            state_d         = S_SRCH_ISSUE;
          end
          default: begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end
      S_INS_SHIFT: begin
        // equal entries stay below the new value
        if (!status_i.slot_zero && status_i.rd_gt) begin
          cmd_o.shift = 1'b1;
        end else begin
          cmd_o.place   = 1'b1;
          cmd_o.finish  = 1'b1;
          cmd_o.pos_sel = POS_SLOT;
          state_d       = S_IDLE;
        end
      end
      S_SRCH_ISSUE: begin
        if (status_i.range_empty) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.probe = 1'b1;
          state_d     = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (status_i.rd_eq) begin
          cmd_o.finish  = 1'b1;
          cmd_o.found   = 1'b1;
          cmd_o.pos_sel = POS_MID;
          state_d       = S_IDLE;
        end else begin
          cmd_o.narrow = 1'b1;
          state_d      = S_SRCH_ISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/stbs_chk.sv
// ----------------------------------------------------------------------------
// stbs_chk
// Port-level checks for the sorted table core, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_chk import stbs_pkg::*; (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic [OP_W-1:0]                 operation_i,
  input logic signed [ELEMENT_WIDTH-1:0] value_i,
  input logic                            done_o,
  input logic signed [POS_W-1:0]         position_o,
  input logic                            found_o,
  input logic                            table_full_o,
  input logic [CNT_W-1:0]                entry_count_o
);

  // a result ends the command, so the core is free while it is shown
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result shown while busy or without a preceding command");

  a_transfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> position_o != '1 && !table_full_o
      && $unsigned(position_o) < entry_count_o)
    else $error("match reported outside the held entries");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> entry_count_o == CNT_W'(TABLE_DEPTH)
      && position_o == '1 && !found_o)
    else $error("refused insert with inconsistent result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> entry_count_o <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind sorted_table_insert_and_binary_search_core stbs_chk u_stbs_chk (.*);
